// ----- src/kss_pkg.sv -----
`default_nettype none

package kss_pkg;

    localparam int VALUE_W = 32;
    localparam int RANK_W  = 11;

    typedef struct packed {
        logic signed [VALUE_W-1:0] element_value;
        logic                      last_element;
        logic        [RANK_W-1:0]  rank;
    } item_t;

    typedef struct packed {
        logic signed [VALUE_W-1:0] selected_value;
        logic                      rank_error;
    } result_t;

endpackage

`default_nettype wire

// ----- src/kss_ram.sv -----
`default_nettype none

module kss_ram #(
    parameter int DEPTH = 1024,
    parameter int WIDTH = 32
) (
    input  wire logic                     clk,
    input  wire logic                     wr_en,
    input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
    input  wire logic [WIDTH-1:0]         wr_data,
    input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
    output logic      [WIDTH-1:0]         rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        rd_data <= mem[rd_addr];
    end

endmodule

`default_nettype wire

// ----- src/kth_smallest_select.sv -----
// kth_smallest_select: k-th smallest of a loaded set of signed Q16.16 values.
//
// Input channel (item/item_valid/item_ready): one element per transfer. The
// transfer with last_element set also carries the rank k (from 1) and starts
// the search. Elements beyond MAX_ELEMENTS are dropped.
// Output channel (result/result_valid/result_ready): one transfer per set,
// either the selected value or rank_error with a zero value.
//
// Loading accepts one element per cycle while no result waits on result_ready.
// Selection runs quickselect in place in a single-port-read, single-port-write
// store with a registered read: each partition pass reads the pivot, scans
// with a read state and a compare state per element, and places the pivot.
// A set of n elements needs about 2n to 3.4n scan steps on average, and O(n^2)
// in the worst case. The result is valid the cycle after the final pass. A
// rank error is reported the cycle after the last element.
// After reset the store needs no clearing; the block is ready at once.
// The input is held off during selection and while a result waits on
// result_ready.
`default_nettype none

module kth_smallest_select #(
    parameter int MAX_ELEMENTS = 1024
) (
    input  wire logic            clk,
    input  wire logic            rst_n,
    input  wire logic            item_valid,
    output logic                 item_ready,
    input  wire kss_pkg::item_t  item,
    output logic                 result_valid,
    input  wire logic            result_ready,
    output kss_pkg::result_t     result
);

    localparam int IDX_W = $clog2(MAX_ELEMENTS);
    localparam int CNT_W = $clog2(MAX_ELEMENTS + 1);
    localparam int CMP_W = (CNT_W > kss_pkg::RANK_W) ? CNT_W : kss_pkg::RANK_W;
    localparam logic [CNT_W-1:0] MAX_CNT = CNT_W'(MAX_ELEMENTS);

    localparam logic [2:0] S_LOAD   = 3'd0;
    localparam logic [2:0] S_PIV_RD = 3'd1;
    localparam logic [2:0] S_PIV    = 3'd2;
    localparam logic [2:0] S_R_RD   = 3'd3;
    localparam logic [2:0] S_R_CMP  = 3'd4;
    localparam logic [2:0] S_L_RD   = 3'd5;
    localparam logic [2:0] S_L_CMP  = 3'd6;
    localparam logic [2:0] S_PLACE  = 3'd7;

    logic [2:0]                       state_reg, state_next;
    logic [CNT_W-1:0]                 count_reg, count_next;
    logic [IDX_W-1:0]                 low_reg, low_next;
    logic [IDX_W-1:0]                 high_reg, high_next;
    logic [IDX_W-1:0]                 left_reg, left_next;
    logic [IDX_W-1:0]                 right_reg, right_next;
    logic [IDX_W-1:0]                 target_reg, target_next;
    logic signed [kss_pkg::VALUE_W-1:0] pivot_reg, pivot_next;
    logic                             result_valid_reg, result_valid_next;
    kss_pkg::result_t                 result_reg, result_next;

    logic                             wr_en;
    logic [IDX_W-1:0]                 wr_addr;
    logic [kss_pkg::VALUE_W-1:0]      wr_data;
    logic [IDX_W-1:0]                 rd_addr;
    logic [kss_pkg::VALUE_W-1:0]      rd_raw;
    logic signed [kss_pkg::VALUE_W-1:0] rd_val;

    logic                             item_xfer;
    logic                             store_full;
    logic [CNT_W-1:0]                 count_inc;
    logic [CMP_W-1:0]                 rank_ext;
    logic [CMP_W-1:0]                 count_ext;
    logic [CMP_W-1:0]                 rank_m1;
    logic [IDX_W-1:0]                 left_inc;
    logic [IDX_W-1:0]                 right_dec;

    kss_ram #(
        .DEPTH (MAX_ELEMENTS),
        .WIDTH (kss_pkg::VALUE_W)
    ) u_store (
        .clk     (clk),
        .wr_en   (wr_en),
        .wr_addr (wr_addr),
        .wr_data (wr_data),
        .rd_addr (rd_addr),
        .rd_data (rd_raw)
    );

    assign rd_val       = $signed(rd_raw);
    assign item_ready   = (state_reg == S_LOAD) && (!result_valid_reg || result_ready);
    assign item_xfer    = item_valid && item_ready;
    assign result_valid = result_valid_reg;
    assign result       = result_reg;

    assign store_full = (count_reg == MAX_CNT);
    assign count_inc  = store_full ? count_reg : count_reg + CNT_W'(1);
    assign rank_ext   = CMP_W'(item.rank);
    assign count_ext  = CMP_W'(count_inc);
    assign rank_m1    = rank_ext - CMP_W'(1);
    assign left_inc   = left_reg + IDX_W'(1);
    assign right_dec  = right_reg - IDX_W'(1);

    always_comb
    begin
        unique case (state_reg)
            S_PIV_RD: rd_addr = low_reg;
            S_R_RD:   rd_addr = right_reg;
            S_L_RD:   rd_addr = left_reg;
            default:  rd_addr = low_reg;
        endcase
    end

    always_comb
    begin
        state_next        = state_reg;
        count_next        = count_reg;
        low_next          = low_reg;
        high_next         = high_reg;
        left_next         = left_reg;
        right_next        = right_reg;
        target_next       = target_reg;
        pivot_next        = pivot_reg;
        result_valid_next = result_valid_reg && !result_ready;
        result_next       = result_reg;
        wr_en             = 1'b0;
        wr_addr           = left_reg;
        wr_data           = pivot_reg;

        unique case (state_reg)
            S_LOAD:
            begin
                if (item_xfer)
                begin
                    wr_en      = !store_full;
                    wr_addr    = count_reg[IDX_W-1:0];
                    wr_data    = item.element_value;
                    count_next = count_inc;
                    if (item.last_element)
                    begin
                        count_next = '0;
                        if ((rank_ext == '0) || (rank_ext > count_ext))
                        begin
                            result_valid_next          = 1'b1;
                            result_next.selected_value = '0;
                            result_next.rank_error     = 1'b1;
                        end
                        else
                        begin
                            target_next = rank_m1[IDX_W-1:0];
                            low_next    = '0;
                            high_next   = IDX_W'(count_inc - CNT_W'(1));
                            state_next  = S_PIV_RD;
                        end
                    end
                end
            end
            S_PIV_RD:
            begin
                state_next = S_PIV;
            end
            S_PIV:
            begin
                pivot_next = rd_val;
                left_next  = low_reg;
                right_next = high_reg;
                state_next = (low_reg < high_reg) ? S_R_RD : S_PLACE;
            end
            S_R_RD:
            begin
                state_next = S_R_CMP;
            end
            S_R_CMP:
            begin
                if (pivot_reg <= rd_val)
                begin
                    right_next = right_dec;
                    state_next = (left_reg < right_dec) ? S_R_RD : S_PLACE;
                end
                else
                begin
                    wr_en      = 1'b1;
                    wr_addr    = left_reg;
                    wr_data    = rd_raw;
                    left_next  = left_inc;
                    state_next = (left_inc < right_reg) ? S_L_RD : S_PLACE;
                end
            end
            S_L_RD:
            begin
                state_next = S_L_CMP;
            end
            S_L_CMP:
            begin
                if (pivot_reg >= rd_val)
                begin
                    left_next  = left_inc;
                    state_next = (left_inc < right_reg) ? S_L_RD : S_PLACE;
                end
                else
                begin
                    wr_en      = 1'b1;
                    wr_addr    = right_reg;
                    wr_data    = rd_raw;
                    right_next = right_dec;
                    state_next = (left_reg < right_dec) ? S_R_RD : S_PLACE;
                end
            end
            S_PLACE:
            begin
                wr_en   = 1'b1;
                wr_addr = left_reg;
                wr_data = pivot_reg;
                priority if (left_reg == target_reg)
                begin
                    result_valid_next          = 1'b1;
                    result_next.selected_value = pivot_reg;
                    result_next.rank_error     = 1'b0;
                    state_next                 = S_LOAD;
                end
                else if (left_reg > target_reg)
                begin
                    high_next  = left_reg - IDX_W'(1);
                    state_next = S_PIV_RD;
                end
                else
                begin
                    low_next   = left_inc;
                    state_next = S_PIV_RD;
                end
            end
            default:
            begin
                state_next = S_LOAD;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg        <= S_LOAD;
            count_reg        <= '0;
            low_reg          <= '0;
            high_reg         <= '0;
            left_reg         <= '0;
            right_reg        <= '0;
            target_reg       <= '0;
            pivot_reg        <= '0;
            result_valid_reg <= 1'b0;
            result_reg       <= '0;
        end
        else
        begin
            state_reg        <= state_next;
            count_reg        <= count_next;
            low_reg          <= low_next;
            high_reg         <= high_next;
            left_reg         <= left_next;
            right_reg        <= right_next;
            target_reg       <= target_next;
            pivot_reg        <= pivot_next;
            result_valid_reg <= result_valid_next;
            result_reg       <= result_next;
        end
    end

`ifndef ASSERT_OFF
    a_scan_open: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_R_CMP || state_reg == S_L_CMP) |-> (left_reg < right_reg))
        else $error("scan compare with closed window");

    a_target_in_range: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_PIV_RD) |-> (low_reg <= target_reg && target_reg <= high_reg))
        else $error("target outside active range");

    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= MAX_CNT)
        else $error("element count overflow");

    a_error_zero: assert property (@(posedge clk) disable iff (!rst_n)
        (result_valid_reg && result_reg.rank_error) |-> (result_reg.selected_value == '0))
        else $error("rank error with nonzero value");
`endif

endmodule

`default_nettype wire

// ----- tb/kth_smallest_select_tb.sv -----
`timescale 1ns / 100ps

module kth_smallest_select_tb;

    localparam int unsigned STORE_DEPTH    = 1024;
    localparam int unsigned RANDOM_ITEMS   = 500;
    localparam int unsigned WATCHDOG_LIMIT = 200000;
    localparam int unsigned LONG_HOLD      = 300;
    localparam int unsigned DRAIN_CYCLES   = 50;
    localparam int unsigned DIRECTED_ROWS  = 24;

    localparam logic signed [kss_pkg::VALUE_W-1:0] VALUE_MAX = 32'sh7FFF_FFFF;
    localparam logic signed [kss_pkg::VALUE_W-1:0] VALUE_MIN = 32'sh8000_0000;

    typedef enum int
    {
        FILL_RANDOM,
        FILL_DUPLICATES,
        FILL_EXTREMES,
        FILL_ASCENDING,
        FILL_DESCENDING
    } fill_mode_t;

    typedef struct packed {
        logic signed [kss_pkg::VALUE_W-1:0] value;
        logic                               last;
        logic        [kss_pkg::RANK_W-1:0]  rank;
        logic                               typed;
        logic signed [kss_pkg::VALUE_W-1:0] exp_value;
        logic                               exp_error;
    } stim_row_t;

    logic             clk          = 1'b0;
    logic             rst_n        = 1'b0;
    logic             item_valid   = 1'b0;
    logic             item_ready;
    kss_pkg::item_t   item         = '0;
    logic             result_valid;
    logic             result_ready = 1'b0;
    kss_pkg::result_t result;

    // set being loaded, as the block sees it
    logic signed [kss_pkg::VALUE_W-1:0] held_values [STORE_DEPTH];
    int unsigned                        held_count = 0;

    kss_pkg::result_t pending_results [$];
    kss_pkg::result_t oldest_result;
    bit               typed_row = 1'b0;
    kss_pkg::result_t typed_result = '0;
    int unsigned      error_count = 0;
    int unsigned      quiet_cycles = 0;
    int unsigned      results_taken = 0;
    bit               sender_calm = 1'b0;

    stim_row_t directed_rows [DIRECTED_ROWS] = '{
        '{VALUE_MAX,      1'b1, 11'd1,    1'b1, VALUE_MAX, 1'b0},
        '{VALUE_MIN,      1'b1, 11'd1,    1'b1, VALUE_MIN, 1'b0},
        '{32'sd5,         1'b1, 11'd0,    1'b1, 32'sd0,    1'b1},
        '{32'sd3,         1'b0, 11'h7FF,  1'b0, 32'sd0,    1'b0},
        '{32'sd7,         1'b1, 11'd3,    1'b1, 32'sd0,    1'b1},
        '{-32'sd1,        1'b0, 11'd0,    1'b0, 32'sd0,    1'b0},
        '{VALUE_MAX,      1'b0, 11'd0,    1'b0, 32'sd0,    1'b0},
        '{VALUE_MIN,      1'b1, 11'd1024, 1'b1, 32'sd0,    1'b1},
        '{VALUE_MIN,      1'b0, 11'd0,    1'b0, 32'sd0,    1'b0},
        '{VALUE_MAX,      1'b0, 11'd0,    1'b0, 32'sd0,    1'b0},
        '{32'sd0,         1'b0, 11'd0,    1'b0, 32'sd0,    1'b0},
        '{-32'sd1,        1'b1, 11'd2,    1'b0, 32'sd0,    1'b0},
        '{32'sd4,         1'b0, 11'd0,    1'b0, 32'sd0,    1'b0},
        '{32'sd4,         1'b0, 11'd0,    1'b0, 32'sd0,    1'b0},
        '{32'sd4,         1'b1, 11'd2,    1'b0, 32'sd0,    1'b0},
        '{32'sd5,         1'b0, 11'd0,    1'b0, 32'sd0,    1'b0},
        '{32'sd4,         1'b0, 11'd0,    1'b0, 32'sd0,    1'b0},
        '{32'sd3,         1'b0, 11'd0,    1'b0, 32'sd0,    1'b0},
        '{32'sd2,         1'b0, 11'd0,    1'b0, 32'sd0,    1'b0},
        '{32'sd1,         1'b1, 11'd1,    1'b0, 32'sd0,    1'b0},
        '{32'sh0001_0000, 1'b0, 11'd0,    1'b0, 32'sd0,    1'b0},
        '{32'sh0002_0000, 1'b0, 11'd0,    1'b0, 32'sd0,    1'b0},
        '{32'sh0003_0000, 1'b0, 11'd0,    1'b0, 32'sd0,    1'b0},
        '{32'sh0004_0000, 1'b1, 11'd4,    1'b0, 32'sd0,    1'b0}
    };

    kth_smallest_select i_dut (
        .clk          (clk),
        .rst_n        (rst_n),
        .item_valid   (item_valid),
        .item_ready   (item_ready),
        .item         (item),
        .result_valid (result_valid),
        .result_ready (result_ready),
        .result       (result)
    );

    always #10 clk = ~clk;

    // hole-filling quickselect over the held set; rank k counts from 1
    function automatic logic signed [kss_pkg::VALUE_W-1:0] kth_smallest(
        input int unsigned k);
        int unsigned lo;
        int unsigned hi;
        int unsigned left;
        int unsigned right;
        int unsigned target;
        logic signed [kss_pkg::VALUE_W-1:0] pivot;
        target = k - 1;
        lo = 0;
        hi = held_count - 1;
        do
        begin
            pivot = held_values[lo];
            left = lo;
            right = hi;
            while (left < right)
            begin
                while (left < right)
                begin
                    if (pivot <= held_values[right])
                        right--;
                    else
                    begin
                        held_values[left] = held_values[right];
                        left++;
                        break;
                    end
                end
                while (left < right)
                begin
                    if (pivot >= held_values[left])
                        left++;
                    else
                    begin
                        held_values[right] = held_values[left];
                        right--;
                        break;
                    end
                end
            end
            held_values[left] = pivot;
            if (left > target)
                hi = left - 1;
            else if (left < target)
                lo = left + 1;
        end
        while (left != target);
        return pivot;
    endfunction

    function automatic void load_and_select(input kss_pkg::item_t it);
        kss_pkg::result_t predicted;
        if (held_count < STORE_DEPTH)
        begin
            held_values[held_count] = it.element_value;
            held_count++;
        end
        if (!it.last_element)
            return;
        if (it.rank == 0 || it.rank > held_count)
        begin
            predicted.selected_value = '0;
            predicted.rank_error = 1'b1;
        end
        else
        begin
            predicted.selected_value = kth_smallest(it.rank);
            predicted.rank_error = 1'b0;
        end
        held_count = 0;
        pending_results.push_back(typed_row ? typed_result : predicted);
    endfunction

    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (item_valid && item_ready)
                load_and_select(item);
            if (result_valid && result_ready)
            begin
                if (pending_results.size() == 0)
                begin
                    $display("%0t: unexpected result value %0d error %0b", $time,
                             result.selected_value, result.rank_error);
                    error_count++;
                end
                else
                begin
                    oldest_result = pending_results.pop_front();
                    if (result.selected_value !== oldest_result.selected_value)
                    begin
                        $display("%0t: selected_value expected %0d, got %0d", $time,
                                 oldest_result.selected_value, result.selected_value);
                        error_count++;
                    end
                    if (result.rank_error !== oldest_result.rank_error)
                    begin
                        $display("%0t: rank_error expected %0b, got %0b", $time,
                                 oldest_result.rank_error, result.rank_error);
                        error_count++;
                    end
                end
            end
        end
    end

    always @(posedge clk)
    begin
        if (!rst_n || (item_valid && item_ready) || (result_valid && result_ready))
            quiet_cycles <= 0;
        else
        begin
            quiet_cycles <= quiet_cycles + 1;
            if (quiet_cycles == WATCHDOG_LIMIT)
            begin
                $display("%0t: no transfer for %0d cycles", $time, WATCHDOG_LIMIT);
                $display("Testbench completed WITH ERRORS");
                $finish;
            end
        end
    end

    initial
    begin : result_sink
        int unsigned stall;
        bit calm;
        calm = 1'b0;
        stall = $urandom_range(0, 11);
        @(posedge rst_n);
        forever
        begin
            @(negedge clk);
            if (stall > 0)
            begin
                result_ready <= 1'b0;
                stall--;
            end
            else
                result_ready <= 1'b1;
            @(posedge clk);
            if (result_valid && result_ready)
            begin
                results_taken++;
                // long hold so the block backs up onto its input
                if (results_taken % 100 == 3)
                    stall = LONG_HOLD;
                else
                begin
                    if ($urandom_range(0, 29) == 0)
                        calm = !calm;
                    stall = calm ? 0 : $urandom_range(0, 11);
                end
            end
        end
    end

    // entered and left at a falling edge
    task automatic send_item(input logic signed [kss_pkg::VALUE_W-1:0] value,
                             input logic last,
                             input logic [kss_pkg::RANK_W-1:0] rank);
        int unsigned gap;
        if ($urandom_range(0, 29) == 0)
            sender_calm = !sender_calm;
        gap = sender_calm ? 0 : $urandom_range(0, 11);
        if (gap > 0)
        begin
            item_valid <= 1'b0;
            repeat (gap) @(negedge clk);
        end
        item.element_value <= value;
        item.last_element <= last;
        item.rank <= rank;
        item_valid <= 1'b1;
        do
            @(posedge clk);
        while (!item_ready);
        @(negedge clk);
    endtask

    function automatic logic signed [kss_pkg::VALUE_W-1:0] draw_value(
        input fill_mode_t mode, input int unsigned idx);
        case (mode)
            FILL_DUPLICATES: return int'($urandom_range(0, 6)) - 3;
            FILL_EXTREMES:
                case ($urandom_range(0, 5))
                    0: return VALUE_MIN;
                    1: return VALUE_MAX;
                    2: return -32'sd1;
                    3: return 32'sd0;
                    4: return 32'sd1;
                    default: return 32'sh0001_0000;
                endcase
            FILL_ASCENDING: return int'(idx) * 32'sh0001_0000 - 32'sh0010_0000;
            FILL_DESCENDING: return 32'sh0010_0000 - int'(idx) * 32'sh0000_8000;
            default: return $urandom;
        endcase
    endfunction

    initial
    begin : stimulus
        int unsigned sent;
        int unsigned n;
        int unsigned pick;
        logic [kss_pkg::RANK_W-1:0] rank;
        bit full_done;
        fill_mode_t mode;
        sent = 0;
        full_done = 1'b0;
        repeat (4) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;
        @(negedge clk);

        foreach (directed_rows[i])
        begin
            typed_row = directed_rows[i].typed;
            typed_result.selected_value = directed_rows[i].exp_value;
            typed_result.rank_error = directed_rows[i].exp_error;
            send_item(directed_rows[i].value, directed_rows[i].last, directed_rows[i].rank);
        end
        typed_row = 1'b0;

        while (sent < RANDOM_ITEMS)
        begin
            if (!full_done && sent >= RANDOM_ITEMS / 2)
            begin
                // full store, then extra elements that are dropped, last one included
                full_done = 1'b1;
                for (int unsigned i = 0; i < STORE_DEPTH + 3; i++)
                    send_item(draw_value(FILL_RANDOM, i), 1'b0,
                              kss_pkg::RANK_W'($urandom_range(0, 2047)));
                send_item($urandom, 1'b1,
                          kss_pkg::RANK_W'($urandom_range(1, STORE_DEPTH)));
            end
            n = ($urandom_range(0, 9) == 0) ? $urandom_range(17, 64) : $urandom_range(1, 16);
            mode = fill_mode_t'($urandom_range(0, 4));
            pick = $urandom_range(0, 19);
            if (pick == 0)
                rank = '0;
            else if (pick <= 2)
                rank = kss_pkg::RANK_W'($urandom_range(n + 1, STORE_DEPTH));
            else
                rank = kss_pkg::RANK_W'($urandom_range(1, n));
            for (int unsigned i = 0; i < n; i++)
                send_item(draw_value(mode, i), i == n - 1,
                          (i == n - 1) ? rank : kss_pkg::RANK_W'($urandom_range(0, 2047)));
            sent += n;
        end
        item_valid <= 1'b0;

        while (pending_results.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
        if (error_count == 0)
            $display("Testbench completed without errors");
        else
            $display("Testbench completed WITH ERRORS");
        $finish;
    end

endmodule
